@@ hw/rtl/pcg32_bounded_random_macros.svh @@
// Assertion macros for the PCG32 bounded random block.
// Used by the port checker; no other dependencies.
`ifndef PCG32_BOUNDED_RANDOM_MACROS_SVH
`define PCG32_BOUNDED_RANDOM_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pcg32br_pkg.sv @@
// Shared types, codes and the XSH-RR output permutation for the PCG32 block.
// No dependencies.
`default_nettype none

package pcg32br_pkg;

   typedef logic [63:0] word64_type;
   typedef logic [31:0] word32_type;

   localparam int CSR_INDEX_W = 2;

   // command codes
   localparam logic [1:0] CMD_RAW    = 2'd0;
   localparam logic [1:0] CMD_RANGED = 2'd1;
   localparam logic [1:0] CMD_RESEED = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MULT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INC  = 2'd1;

   localparam word64_type MULT_RESET = 64'd6364136223846793005;
   localparam word64_type INC_RESET  = 64'd1442695040888963407;

   // last draw index of a ranged draw (256 draws at most)
   localparam logic [7:0] LAST_DRAW = 8'hFF;

   localparam int XSH_SHIFT = 18;
   localparam int XSH_OUT   = 27;
   localparam int ROT_POS   = 59;

   function automatic word32_type xsh_rr(input word64_type s);
      word64_type mixed;
      word32_type x;
      logic [4:0] r;
      logic [63:0] doubled;
      mixed   = ((s >> XSH_SHIFT) ^ s) >> XSH_OUT;
      x       = mixed[31:0];
      r       = s[ROT_POS+4:ROT_POS];
      doubled = {x, x} >> r;
      return doubled[31:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pcg32br_channels.sv @@
// Handshake channels of the PCG32 block: request and response.
// Depends on pcg32br_pkg.
`default_nettype none

interface pcg32br_req_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   pcg32br_pkg::word32_type range_low;
   pcg32br_pkg::word32_type range_high;
   pcg32br_pkg::word64_type seed_value;

   modport source (output valid, command, range_low, range_high, seed_value,
                   input ready);
   modport sink (input valid, command, range_low, range_high, seed_value,
                 output ready);
endinterface

interface pcg32br_rsp_if;
   logic                    valid;
   logic                    ready;
   pcg32br_pkg::word32_type random_value;

   modport source (output valid, random_value, input ready);
   modport sink (input valid, random_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pcg32br_mul.sv @@
// 64x64 multiply-add modulo 2^64 on one shared 32x32 multiplier, four steps.
// Depends on pcg32br_pkg. Operands must hold while busy.
`default_nettype none

module pcg32br_mul (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  pcg32br_pkg::word64_type op_a,
   input  pcg32br_pkg::word64_type op_b,
   input  pcg32br_pkg::word64_type addend,
   output logic                    done,
   output pcg32br_pkg::word64_type result
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [1:0]              phase_ff, phase_in;
   pcg32br_pkg::word64_type pp_ff, pp_in;
   pcg32br_pkg::word64_type acc_ff, acc_in;
   pcg32br_pkg::word32_type mul_x, mul_y;
   pcg32br_pkg::word64_type product;

   // only the low half of each cross product reaches bits below 64
   always_comb begin
      case (phase_ff)
         2'd0: begin
            mul_x = op_a[31:0];
            mul_y = op_b[31:0];
         end
         2'd1: begin
            mul_x = op_a[31:0];
            mul_y = op_b[63:32];
         end
         default: begin
            mul_x = op_a[63:32];
            mul_y = op_b[31:0];
         end
      endcase
      product = 64'(mul_x) * 64'(mul_y);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            2'd0: begin
               pp_in = product;
            end
            2'd1: begin
               acc_in = addend + pp_ff;
               pp_in  = product;
            end
            2'd2: begin
               acc_in = acc_ff + {pp_ff[31:0], 32'd0};
               pp_in  = product;
            end
            default: begin
               acc_in  = acc_ff + {pp_ff[31:0], 32'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pcg32br_div.sv @@
// 32-bit restoring divider giving the remainder, one bit per cycle.
// Depends on pcg32br_pkg. Divisor must be non-zero.
`default_nettype none

module pcg32br_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  pcg32br_pkg::word32_type dividend,
   input  pcg32br_pkg::word32_type divisor,
   output logic                    done,
   output pcg32br_pkg::word32_type remainder
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [4:0]              cnt_ff, cnt_in;
   pcg32br_pkg::word32_type rem_ff, rem_in;
   pcg32br_pkg::word32_type dvd_ff, dvd_in;
   pcg32br_pkg::word32_type dvs_ff, dvs_in;
   logic [32:0]             shifted;
   logic [32:0]             diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // diff[32] set means the partial remainder is below the divisor
         rem_in = diff[32] ? shifted[31:0] : diff[31:0];
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pcg32_bounded_random.sv @@
// Top level of the PCG32 bounded random block: sequencer, state and registers.
// Depends on pcg32br_pkg, pcg32br_channels, pcg32br_mul and pcg32br_div.
//
//   channel    role    payload
//   req_chan   in      command, range_low, range_high, seed_value
//   rsp_chan   out     random_value
//   csr_*      in      write enable, index, 64-bit data (no read-back)
//
// Each generator step runs on the four-step multiplier; a ranged draw also uses
// two passes of the bit-serial divider (threshold, reduction).
// One transaction is worked on at a time; req ready is high only when idle.
// Synchronous reset clears the generator state to zero and restores registers.
// A finished result waits in the sequencer until the output register is free.
`default_nettype none

module pcg32_bounded_random (
   input  logic                                 clock,
   input  logic                                 reset,
   pcg32br_req_if.sink                          req_chan,
   pcg32br_rsp_if.source                        rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [pcg32br_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  pcg32br_pkg::word64_type              csr_write_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_THRESH = 3'd2;
   localparam logic [2:0] ST_DRAW   = 3'd3;
   localparam logic [2:0] ST_ADV    = 3'd4;
   localparam logic [2:0] ST_SEED   = 3'd5;
   localparam logic [2:0] ST_MOD    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              cmd_ff, cmd_in;
   pcg32br_pkg::word32_type lo_ff, lo_in;
   pcg32br_pkg::word32_type hi_ff, hi_in;
   pcg32br_pkg::word64_type seed_ff, seed_in;
   pcg32br_pkg::word32_type span_ff, span_in;
   pcg32br_pkg::word32_type thr_ff, thr_in;
   pcg32br_pkg::word32_type draw_ff, draw_in;
   pcg32br_pkg::word32_type res_ff, res_in;
   logic [7:0]              cnt_ff, cnt_in;
   logic                    second_ff, second_in;
   pcg32br_pkg::word64_type gen_ff, gen_in;
   pcg32br_pkg::word64_type mult_ff, mult_in;
   pcg32br_pkg::word64_type inc_ff, inc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pcg32br_pkg::word32_type rsp_value_ff, rsp_value_in;

   pcg32br_pkg::word32_type span_diff;
   pcg32br_pkg::word32_type span_c;
   logic                    mul_start, mul_done;
   pcg32br_pkg::word64_type mul_result;
   logic                    div_start, div_done;
   pcg32br_pkg::word32_type div_dividend, div_divisor, div_rem;

   pcg32br_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (gen_ff),
      .op_b   (mult_ff),
      .addend (inc_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   pcg32br_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign span_diff = hi_ff - lo_ff;
   assign span_c    = span_diff + 32'd1;

   // threshold = (2^32 - span) mod span, and 2^32 - span is ~(hi - lo)
   assign div_dividend = (state_ff == ST_SETUP) ? ~span_diff : draw_ff;
   assign div_divisor  = (state_ff == ST_SETUP) ? span_c : span_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      seed_in      = seed_ff;
      span_in      = span_ff;
      thr_in       = thr_ff;
      draw_in      = draw_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      second_in    = second_ff;
      gen_in       = gen_ff;
      mult_in      = mult_ff;
      inc_in       = inc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            pcg32br_pkg::REG_MULT: mult_in = csr_write_data;
            pcg32br_pkg::REG_INC:  inc_in  = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in    = req_chan.command;
               lo_in     = req_chan.range_low;
               hi_in     = req_chan.range_high;
               seed_in   = req_chan.seed_value;
               cnt_in    = 8'd0;
               second_in = 1'b0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            case (cmd_ff)
               pcg32br_pkg::CMD_RAW:    state_in = ST_DRAW;
               pcg32br_pkg::CMD_RESEED: state_in = ST_DRAW;
               pcg32br_pkg::CMD_RANGED: begin
                  span_in = span_c;
                  // single-value, inverted or full range: answer is the low bound
                  if (lo_ff >= hi_ff || span_c == 32'd0) begin
                     res_in   = lo_ff;
                     state_in = ST_OUT;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_THRESH;
                  end
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_THRESH: begin
            if (div_done) begin
               thr_in   = div_rem;
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            mul_start = 1'b1;
            draw_in   = pcg32br_pkg::xsh_rr(gen_ff);
            state_in  = ST_ADV;
         end
         ST_ADV: begin
            if (mul_done) begin
               gen_in = mul_result;
               case (cmd_ff)
                  pcg32br_pkg::CMD_RANGED: begin
                     if (draw_ff >= thr_ff || cnt_ff == pcg32br_pkg::LAST_DRAW) begin
                        div_start = 1'b1;
                        state_in  = ST_MOD;
                     end else begin
                        cnt_in   = cnt_ff + 8'd1;
                        state_in = ST_DRAW;
                     end
                  end
                  pcg32br_pkg::CMD_RESEED: begin
                     if (second_ff) begin
                        res_in   = '0;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_SEED;
                     end
                  end
                  default: begin
                     res_in   = draw_ff;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_SEED: begin
            gen_in    = gen_ff + seed_ff;
            second_in = 1'b1;
            state_in  = ST_DRAW;
         end
         ST_MOD: begin
            if (div_done) begin
               res_in   = lo_ff + div_rem;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gen_ff       <= '0;
         mult_ff      <= pcg32br_pkg::MULT_RESET;
         inc_ff       <= pcg32br_pkg::INC_RESET;
         cnt_ff       <= 8'd0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_ff       <= gen_in;
         mult_ff      <= mult_in;
         inc_ff       <= inc_in;
         cnt_ff       <= cnt_in;
         second_ff    <= second_in;
      end
      cmd_ff       <= cmd_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      seed_ff      <= seed_in;
      span_ff      <= span_in;
      thr_ff       <= thr_in;
      draw_ff      <= draw_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.random_value = rsp_value_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pcg32br_checker.sv @@
// Port-level checks for the PCG32 bounded random block, bound to the top level.
// Depends on pcg32_bounded_random_macros.svh.
`default_nettype none

`include "pcg32_bounded_random_macros.svh"

module pcg32br_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_random_value
);

   // the block works on one transaction at a time
   `PCG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted while previous transaction still running")

   // a new result is only produced by a transaction in progress
   `PCG_ASSERT_SAME(a_result_from_work, clock, reset, $rose(rsp_valid), !$past(req_ready), "response appeared without a transaction in progress")

   // a stalled response holds
   `PCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_random_value), "stalled response changed")

endmodule

bind pcg32_bounded_random pcg32br_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_random_value (rsp_chan.random_value)
);

`default_nettype wire
